// ----- rtl/core/eig2_pkg.sv -----
// ----------------------------------------------------------------------------
// eig2_pkg
// Shared widths, defaults and the word that moves along the root chain.
// ----------------------------------------------------------------------------
package eig2_pkg;

  localparam int unsigned ENTRY_WIDTH_DEF = 16;
  localparam int unsigned DISC_W          = 36;
  localparam int unsigned LAMBDA_W        = 18;
  localparam int unsigned ROOT_W          = DISC_W / 2;
  localparam int unsigned REM_W           = ROOT_W + 2;

  typedef struct packed {
    logic                     valid;
    logic signed [DISC_W-1:0] disc;
    logic [DISC_W-1:0]        rad;
    logic [REM_W-1:0]         rem;
    logic [ROOT_W-1:0]        root;
  } sqrt_word_t;

endpackage

// ----- rtl/core/eig2_front.sv -----
// ----------------------------------------------------------------------------
// eig2_front
// Four-stage front end: capture entries, form products and trace, form the
// determinant and trace squared, then the clamped discriminant.
// ----------------------------------------------------------------------------
module eig2_front #(
  parameter int unsigned ENTRY_WIDTH = eig2_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ENTRY_WIDTH-1:0]    m00_i,
  input  logic signed [ENTRY_WIDTH-1:0]    m01_i,
  input  logic signed [ENTRY_WIDTH-1:0]    m10_i,
  input  logic signed [ENTRY_WIDTH-1:0]    m11_i,
  output logic                             valid_o,
  output logic signed [eig2_pkg::DISC_W-1:0] disc_o,
  output logic signed [ENTRY_WIDTH:0]      tr_o
);

  localparam int unsigned TW = ENTRY_WIDTH + 1;
  localparam int unsigned PW = 2 * ENTRY_WIDTH;
  localparam int unsigned XW = 2 * ENTRY_WIDTH + 4;
  localparam bit          SAT_EN  = XW > 64;
  localparam bit          CLAMP_EN = XW > eig2_pkg::DISC_W;
  localparam logic signed [XW-1:0] SAT_MAX = XW'(64'sh7FFF_FFFF_FFFF_FFFF);
  localparam logic signed [XW-1:0] SAT_MIN = XW'(64'sh8000_0000_0000_0000);
  localparam logic signed [XW-1:0] DISC_MAX = XW'(36'sh7_FFFF_FFFF);
  localparam logic signed [XW-1:0] DISC_MIN = XW'(36'sh8_0000_0000);

  function automatic logic signed [XW-1:0] sat64(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (SAT_EN && (v > SAT_MAX)) r = SAT_MAX;
    if (SAT_EN && (v < SAT_MIN)) r = SAT_MIN;
    return r;
  endfunction

  logic                         v1_q, v2_q, v3_q, v4_q;
  logic signed [ENTRY_WIDTH-1:0] a_q, b_q, c_q, d_q;
  logic signed [PW-1:0]         ad_d, bc_d, ad_q, bc_q;
  logic signed [TW-1:0]         tr2_d, tr2_q, tr3_q, tr4_q;
  logic signed [2*TW-1:0]       trsq_full;
  logic signed [XW-1:0]         det_d, det_q, trsq_d, trsq_q;
  logic signed [XW-1:0]         fdet, disc_x, disc_c;
  logic signed [eig2_pkg::DISC_W-1:0] disc_d, disc_q;

  always_comb begin
    ad_d      = a_q * d_q;
    bc_d      = b_q * c_q;
    tr2_d     = TW'(a_q) + TW'(d_q);
    trsq_full = tr2_q * tr2_q;
    det_d     = sat64(XW'(ad_q) - XW'(bc_q));
    trsq_d    = sat64(XW'(trsq_full));
    fdet      = sat64(det_q <<< 2);
    disc_x    = trsq_q - fdet;
    disc_c    = disc_x;
    if (CLAMP_EN && (disc_x > DISC_MAX)) disc_c = DISC_MAX;
    if (CLAMP_EN && (disc_x < DISC_MIN)) disc_c = DISC_MIN;
    disc_d    = eig2_pkg::DISC_W'(disc_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= m00_i;
    b_q    <= m01_i;
    c_q    <= m10_i;
    d_q    <= m11_i;
    ad_q   <= ad_d;
    bc_q   <= bc_d;
    tr2_q  <= tr2_d;
    det_q  <= det_d;
    trsq_q <= trsq_d;
    tr3_q  <= tr2_q;
    disc_q <= disc_d;
    tr4_q  <= tr3_q;
  end

  assign valid_o = v4_q;
  assign disc_o  = disc_q;
  assign tr_o    = tr4_q;

endmodule

// ----- rtl/core/eig2_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// eig2_sqrt_cell
// One restoring square-root step: take two radicand bits, try the next root
// bit, and hand the word on to the next cell.
// ----------------------------------------------------------------------------
module eig2_sqrt_cell #(
  parameter int unsigned TRACE_W = eig2_pkg::ENTRY_WIDTH_DEF + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  eig2_pkg::sqrt_word_t      word_i,
  input  logic signed [TRACE_W-1:0] tr_i,
  output eig2_pkg::sqrt_word_t      word_o,
  output logic signed [TRACE_W-1:0] tr_o
);

  localparam int unsigned TW_REM = eig2_pkg::REM_W + 2;

  logic                   valid_q;
  eig2_pkg::sqrt_word_t   word_d, word_q;
  logic signed [TRACE_W-1:0] tr_q;
  logic [TW_REM-1:0]      rem_t, trial;
  logic                   fits;

  always_comb begin
    rem_t  = {word_i.rem, word_i.rad[eig2_pkg::DISC_W-1 -: 2]};
    trial  = TW_REM'({word_i.root, 2'b01});
    fits   = rem_t >= trial;
    word_d = word_i;
    word_d.rad  = word_i.rad << 2;
    word_d.rem  = fits ? eig2_pkg::REM_W'(rem_t - trial) : eig2_pkg::REM_W'(rem_t);
    word_d.root = {word_i.root[eig2_pkg::ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    tr_q   <= tr_i;
  end

  always_comb begin
    word_o       = word_q;
    word_o.valid = valid_q;
  end

  assign tr_o   = tr_q;

endmodule

// ----- rtl/core/eigenvalues_2x2_real.sv -----
// ----------------------------------------------------------------------------
// eigenvalues_2x2_real
// Real eigenvalues of a 2x2 Q8.8 matrix from trace, determinant and the
// floored square root of the discriminant.
// Each matrix passes four front stages, the 18-cell root chain and one output stage.
// Throughput: one matrix per cycle; busy stays low.
// Reset: clears only the valid bits along the pipeline; words in flight are dropped and none is made.
// The receiver cannot stall: every result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module eigenvalues_2x2_real #(
  parameter int unsigned ENTRY_WIDTH = eig2_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ENTRY_WIDTH-1:0]        m00_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m01_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m10_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m11_i,
  output logic                                 done_o,
  output logic                                 real_roots_o,
  output logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_high_o,
  output logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_low_o,
  output logic signed [eig2_pkg::DISC_W-1:0]   disc_value_o
);

  localparam int unsigned TW = ENTRY_WIDTH + 1;
  localparam int unsigned LW = ((TW > eig2_pkg::ROOT_W + 1) ? TW : eig2_pkg::ROOT_W + 1) + 1;
  localparam logic signed [LW-1:0] LAM_MAX = LW'(18'sh1FFFF);
  localparam logic signed [LW-1:0] LAM_MIN = LW'(18'sh20000);

  logic                               f_valid;
  logic signed [eig2_pkg::DISC_W-1:0] f_disc;
  logic signed [TW-1:0]               f_tr;

  eig2_pkg::sqrt_word_t               chain_w [0:eig2_pkg::ROOT_W];
  logic signed [TW-1:0]               chain_tr [0:eig2_pkg::ROOT_W];

  logic signed [LW-1:0]               root_x, sum_hi, sum_lo, half_hi, half_lo;
  logic signed [LW-1:0]               clamp_hi, clamp_lo;
  logic                               real_d;

  logic                               done_q;
  logic                               real_q;
  logic signed [eig2_pkg::LAMBDA_W-1:0] hi_q, lo_q;
  logic signed [eig2_pkg::DISC_W-1:0] disc_q;

  assign busy = 1'b0;

  eig2_front #(
    .ENTRY_WIDTH(ENTRY_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .m00_i  (m00_i),
    .m01_i  (m01_i),
    .m10_i  (m10_i),
    .m11_i  (m11_i),
    .valid_o(f_valid),
    .disc_o (f_disc),
    .tr_o   (f_tr)
  );

  assign chain_w[0].valid = f_valid;
  assign chain_w[0].disc  = f_disc;
  assign chain_w[0].rad   = f_disc;
  assign chain_w[0].rem   = '0;
  assign chain_w[0].root  = '0;
  assign chain_tr[0]      = f_tr;

  for (genvar g = 0; g < eig2_pkg::ROOT_W; g++) begin : g_cell
    eig2_sqrt_cell #(
      .TRACE_W(TW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .word_i(chain_w[g]),
      .tr_i  (chain_tr[g]),
      .word_o(chain_w[g+1]),
      .tr_o  (chain_tr[g+1])
    );
  end

  always_comb begin
    real_d   = ~chain_w[eig2_pkg::ROOT_W].disc[eig2_pkg::DISC_W-1];
    root_x   = LW'({1'b0, chain_w[eig2_pkg::ROOT_W].root});
    sum_hi   = LW'(chain_tr[eig2_pkg::ROOT_W]) + root_x;
    sum_lo   = LW'(chain_tr[eig2_pkg::ROOT_W]) - root_x;
    half_hi  = sum_hi >>> 1;
    half_lo  = sum_lo >>> 1;
    clamp_hi = half_hi;
    clamp_lo = half_lo;
    if (half_hi > LAM_MAX) clamp_hi = LAM_MAX;
    if (half_hi < LAM_MIN) clamp_hi = LAM_MIN;
    if (half_lo > LAM_MAX) clamp_lo = LAM_MAX;
    if (half_lo < LAM_MIN) clamp_lo = LAM_MIN;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_w[eig2_pkg::ROOT_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    real_q <= real_d;
    hi_q   <= real_d ? eig2_pkg::LAMBDA_W'(clamp_hi) : '0;
    lo_q   <= real_d ? eig2_pkg::LAMBDA_W'(clamp_lo) : '0;
    disc_q <= chain_w[eig2_pkg::ROOT_W].disc;
  end

  assign done_o        = done_q;
  assign real_roots_o  = real_q;
  assign lambda_high_o = hi_q;
  assign lambda_low_o  = lo_q;
  assign disc_value_o  = disc_q;

endmodule

// ----- bench/eigenvalues_2x2_real_checker.sv -----
// ----------------------------------------------------------------------------
// eigenvalues_2x2_real_checker
// Watches the matrix and result channels, predicts every result and compares.
// Each accepted matrix is turned into its expected real_roots, lambda pair and
// discriminant and queued; each done strobe is checked field by field against
// the oldest queued word. The failure count and the number of words still
// awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module eigenvalues_2x2_real_checker #(
  parameter int unsigned ENTRY_WIDTH = eig2_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m00_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m01_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m10_i,
  input  logic signed [ENTRY_WIDTH-1:0]        m11_i,
  input  logic                                 done_i,
  input  logic                                 real_roots_i,
  input  logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_high_i,
  input  logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_low_i,
  input  logic signed [eig2_pkg::DISC_W-1:0]   disc_value_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic                               has_real;
    logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_high;
    logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_low;
    logic signed [eig2_pkg::DISC_W-1:0]   disc;
  } eigen_word_t;

  eigen_word_t eigen_words_q[$];
  int          fail_count = 0;

  function automatic longint clamp_signed(input longint v, input int unsigned w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bit_w;
    res   = 0;
    bit_w = 64'h4000_0000_0000_0000;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(res);
  endfunction

  function automatic eigen_word_t solve_eigenvalues(
    input logic signed [ENTRY_WIDTH-1:0] a,
    input logic signed [ENTRY_WIDTH-1:0] b,
    input logic signed [ENTRY_WIDTH-1:0] c,
    input logic signed [ENTRY_WIDTH-1:0] d
  );
    longint      trace;
    longint      det;
    longint      disc;
    longint      root;
    eigen_word_t w;
    trace = longint'(a) + longint'(d);
    det   = longint'(a) * longint'(d) - longint'(b) * longint'(c);
    disc  = clamp_signed(trace * trace - 64'sd4 * det, eig2_pkg::DISC_W);
    w.disc = disc[eig2_pkg::DISC_W-1:0];
    if (disc < 0) begin
      w.has_real    = 1'b0;
      w.lambda_high = '0;
      w.lambda_low  = '0;
    end else begin
      root          = floor_sqrt(longint'(disc));
      w.has_real    = 1'b1;
      w.lambda_high = eig2_pkg::LAMBDA_W'(clamp_signed((trace + root) >>> 1,
                                                       eig2_pkg::LAMBDA_W));
      w.lambda_low  = eig2_pkg::LAMBDA_W'(clamp_signed((trace - root) >>> 1,
                                                       eig2_pkg::LAMBDA_W));
    end
    return w;
  endfunction

  task automatic report(input string field, input longint want, input longint got);
    fail_count = fail_count + 1;
    if (fail_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    eigen_word_t want;
    if (rst_ni && start_i && !busy_i)
      eigen_words_q.push_back(solve_eigenvalues(m00_i, m01_i, m10_i, m11_i));
    if (rst_ni && done_i) begin
      if (eigen_words_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
          $display("%0t ns: result word with nothing expected, expected none actual %0d",
                   $time, disc_value_i);
      end else begin
        want = eigen_words_q.pop_front();
        if (real_roots_i !== want.has_real)
          report("real_roots", want.has_real, real_roots_i);
        if (lambda_high_i !== want.lambda_high)
          report("lambda_high", want.lambda_high, lambda_high_i);
        if (lambda_low_i !== want.lambda_low)
          report("lambda_low", want.lambda_low, lambda_low_i);
        if (disc_value_i !== want.disc)
          report("disc_value", want.disc, disc_value_i);
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= eigen_words_q.size();
  end

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

endmodule

// ----- bench/eigenvalues_2x2_real_test.sv -----
// ----------------------------------------------------------------------------
// eigenvalues_2x2_real_test
// Stimulus and verdict for the 2x2 real eigenvalue block.
// Drives a directed set of extreme, singular, complex and zero-discriminant
// matrices, then random matrices of mixed shape with random idle bursts;
// a side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module eigenvalues_2x2_real_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRY_W        = eig2_pkg::ENTRY_WIDTH_DEF;
  localparam int          RANDOM_WORDS   = 1300;
  localparam int          CALM_WORDS     = 200;
  localparam int          DRAIN_CYCLES   = 30;
  localparam int          WATCHDOG_LIMIT = 1000;

  typedef logic signed [ENTRY_W-1:0] entry_t;

  localparam entry_t E_MAX = 16'sh7fff;
  localparam entry_t E_MIN = 16'sh8000;
  localparam entry_t E_ONE = 16'sh0100;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 start;
  logic                                 busy;
  entry_t                               m00, m01, m10, m11;
  logic                                 done;
  logic                                 real_roots;
  logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_high;
  logic signed [eig2_pkg::LAMBDA_W-1:0] lambda_low;
  logic signed [eig2_pkg::DISC_W-1:0]   disc_value;
  int                                   fail_count;
  int                                   pending;
  int                                   quiet_cycles;
  bit                                   idling_on;

  eigenvalues_2x2_real #(.ENTRY_WIDTH(ENTRY_W)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .m00_i         (m00),
    .m01_i         (m01),
    .m10_i         (m10),
    .m11_i         (m11),
    .done_o        (done),
    .real_roots_o  (real_roots),
    .lambda_high_o (lambda_high),
    .lambda_low_o  (lambda_low),
    .disc_value_o  (disc_value)
  );

  eigenvalues_2x2_real_checker #(.ENTRY_WIDTH(ENTRY_W)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .m00_i         (m00),
    .m01_i         (m01),
    .m10_i         (m10),
    .m11_i         (m11),
    .done_i        (done),
    .real_roots_i  (real_roots),
    .lambda_high_i (lambda_high),
    .lambda_low_i  (lambda_low),
    .disc_value_i  (disc_value),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || done))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** eigenvalues_2x2_real: FAILED **");
      $finish;
    end
  end

  task automatic drive_matrix(input entry_t a, input entry_t b, input entry_t c,
                              input entry_t d);
    @(negedge clk_i);
    start = 1'b1;
    m00   = a;
    m01   = b;
    m10   = c;
    m11   = d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // drop start and scramble the fields while idle
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start = 1'b0;
      m00   = $urandom;
      m01   = $urandom;
      m10   = $urandom;
      m11   = $urandom;
    end
  endtask

  function automatic entry_t pick_entry(input int shape);
    case (shape)
      0: return entry_t'($urandom_range(0, 1200)) - 16'sd600;
      1: begin
        case ($urandom_range(0, 4))
          0: return E_MAX;
          1: return E_MIN;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: return entry_t'($urandom);
    endcase
  endfunction

  task automatic drive_random_matrix();
    entry_t a, b, c, d;
    int     shape;
    shape = $urandom_range(0, 9);
    a = pick_entry($urandom_range(0, 3));
    b = pick_entry($urandom_range(0, 3));
    c = pick_entry($urandom_range(0, 3));
    d = pick_entry($urandom_range(0, 3));
    case (shape)
      0: c = b;
      1: begin
        d = a;
        if ($urandom_range(0, 1)) b = 16'sd0;
        else c = 16'sd0;
      end
      2: c = -b;
      default: ;
    endcase
    drive_matrix(a, b, c, d);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    m00          = '0;
    m01          = '0;
    m10          = '0;
    m11          = '0;
    quiet_cycles = 0;
    idling_on    = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    hold_off(3);

    drive_matrix(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    drive_matrix(E_ONE, 16'sd0, 16'sd0, E_ONE);
    drive_matrix(E_MAX, E_MAX, E_MAX, E_MAX);
    drive_matrix(E_MIN, E_MIN, E_MIN, E_MIN);
    drive_matrix(E_MAX, E_MIN, E_MIN, E_MAX);
    drive_matrix(E_MIN, E_MAX, E_MAX, E_MIN);
    drive_matrix(E_MAX, E_MAX, E_MAX, E_MIN);
    drive_matrix(E_MIN, E_MIN, E_MAX, E_MIN);
    drive_matrix(E_MIN, E_MAX, E_MAX, E_MIN);
    drive_matrix(16'sd0, E_MAX, E_MIN, 16'sd0);
    drive_matrix(16'sd0, E_MIN, E_MAX, 16'sd0);
    drive_matrix(16'sd0, -E_ONE, E_ONE, 16'sd0);
    drive_matrix(E_ONE, E_ONE, -16'sd1, E_ONE);
    drive_matrix(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    drive_matrix(-16'sd3, 16'sd0, 16'sd0, 16'sd0);
    drive_matrix(-16'sd5, 16'sd1, 16'sd1, 16'sd2);
    drive_matrix(E_ONE, E_ONE, 16'sd0, E_ONE);
    drive_matrix(16'sh0180, 16'sh0040, 16'sh0010, 16'sh0200);
    drive_matrix(16'shff00, 16'sh0000, 16'sh0000, 16'sh0300);
    drive_matrix(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    drive_matrix(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n >= RANDOM_WORDS - CALM_WORDS) idling_on = 1'b0;
      if (idling_on && $urandom_range(0, 3) == 0 && (n % 200) < 150)
        hold_off($urandom_range(1, 11));
      drive_random_matrix();
    end

    @(negedge clk_i);
    start = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** eigenvalues_2x2_real: PASSED **");
    end else begin
      $display("** eigenvalues_2x2_real: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/eig2_pkg.sv
rtl/core/eig2_front.sv
rtl/core/eig2_sqrt_cell.sv
rtl/core/eigenvalues_2x2_real.sv
bench/eigenvalues_2x2_real_checker.sv
bench/eigenvalues_2x2_real_test.sv
